// ----- rtl/core/htbd_pkg.sv -----
// Shared types and constants of the table-driven bit-serial Huffman decoder.
// Used by the front, the command queue, the back end and the top level.
package htbd_pkg;

	localparam int FUNC_W = 2;
	localparam int SYM_W  = 10;
	localparam int LEN_W  = 4;
	localparam int CODE_W = 15;
	localparam int ACC_W  = 17;
	localparam int NB_W   = 5;

	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 16;

	// func codes on the input channel
	localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_BIT   = 2'd2;

	// largest bit count the code accumulator holds, and the bit count that forces an error
	localparam logic [NB_W-1:0] LAST_LENGTH = 5'd16;
	localparam logic [NB_W-1:0] MAX_BITS    = 5'd17;

	// command queue between front and back
	localparam int QDEPTH = 4;
	localparam int QAW    = 2;

	typedef enum logic [1:0] {
		OP_CLEAR,
		OP_LOAD,
		OP_BIT
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [SYM_W-1:0]  symbol;
		logic [LEN_W-1:0]  length;
		logic [CODE_W-1:0] code;
		logic              code_bit;
	} cmd_t;

	typedef struct packed {
		logic            scanning;
		logic [NB_W-1:0] bits_taken;
	} back_stat_t;

endpackage

// ----- rtl/core/htbd_front.sv -----
// Input side of the Huffman decoder: unpacks stream items and turns func into a command.
// Depends on htbd_pkg; feeds htbd_queue.
module htbd_front (
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [htbd_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic [htbd_pkg::FUNC_W-1:0]   s_tuser,
	input  logic                          q_ready,
	output logic                          q_valid,
	output htbd_pkg::cmd_t                q_cmd
);
	import htbd_pkg::*;

	logic known;

	assign s_tready = q_ready;

	always_comb begin
		known           = 1'b1;
		q_cmd.op        = OP_CLEAR;
		q_cmd.symbol    = s_tdata[SYM_W-1:0];
		q_cmd.length    = s_tdata[SYM_W+LEN_W-1:SYM_W];
		q_cmd.code      = s_tdata[SYM_W+LEN_W+CODE_W-1:SYM_W+LEN_W];
		q_cmd.code_bit  = s_tdata[SYM_W+LEN_W+CODE_W];
		case (s_tuser)
			FUNC_CLEAR: q_cmd.op = OP_CLEAR;
			FUNC_LOAD:  q_cmd.op = OP_LOAD;
			FUNC_BIT:   q_cmd.op = OP_BIT;
			default:    known = 1'b0;  // drop unknown func
		endcase
	end

	assign q_valid = s_tvalid && known;

endmodule

// ----- rtl/core/htbd_queue.sv -----
// Short command queue that decouples the decoder front from the table search.
// Depends on htbd_pkg for the command type and depth.
module htbd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  htbd_pkg::cmd_t in_cmd,
	output logic           out_valid,
	input  logic           out_ready,
	output htbd_pkg::cmd_t out_cmd
);
	import htbd_pkg::*;

	cmd_t             slot_q [QDEPTH];
	logic [QAW-1:0]   wr_ptr_q;
	logic [QAW-1:0]   rd_ptr_q;
	logic [QAW:0]     fill_q;
	logic             push;
	logic             pop;

	assign in_ready  = (fill_q != (QAW+1)'(QDEPTH));
	assign out_valid = (fill_q != '0);
	assign out_cmd   = slot_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/core/htbd_back.sv -----
// Back end of the Huffman decoder: code table memory, code accumulator, table scan
// and result register. Depends on htbd_pkg; takes commands from htbd_queue.
module htbd_back #(
	parameter int TABLE_DEPTH = 256,
	parameter int SYMBOL_BITS = 10
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	output logic                        q_pop,
	input  htbd_pkg::cmd_t              q_cmd,
	output logic                        m_valid,
	input  logic                        m_ready,
	output logic [htbd_pkg::SYM_W-1:0]  m_symbol,
	output logic                        m_status,
	output htbd_pkg::back_stat_t        stat
);
	import htbd_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int SW = (SYMBOL_BITS < SYM_W) ? SYMBOL_BITS : SYM_W;

	typedef struct packed {
		logic [SW-1:0]     sym;
		logic [LEN_W-1:0]  len;
		logic [CODE_W-1:0] code;
	} entry_t;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	entry_t            mem [TABLE_DEPTH];
	entry_t            rd_ent_s1;
	logic              rd_vld_s1;
	logic              rd_last_s1;

	state_t            st_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     scan_q;
	logic [ACC_W-1:0]  accum_q;
	logic [NB_W-1:0]   nbits_q;
	logic              m_valid_q;
	logic [SYM_W-1:0]  m_symbol_q;
	logic              m_status_q;

	logic              out_free;
	logic              room;
	logic              issue;
	logic              hit;
	logic              miss_done;
	logic              res_load;
	logic [ACC_W-1:0]  next_accum;
	logic [NB_W-1:0]   next_nbits;
	entry_t            wr_ent;

	always_comb begin
		out_free   = !m_valid_q || m_ready;
		room       = (count_q < CW'(TABLE_DEPTH));
		q_pop      = q_valid && (st_q == ST_IDLE) && ((q_cmd.op != OP_BIT) || out_free);
		next_accum = {accum_q[ACC_W-2:0], q_cmd.code_bit};
		next_nbits = nbits_q + 1'b1;
		issue      = (st_q == ST_SCAN) && (scan_q < count_q);
		hit        = rd_vld_s1 && ({1'b0, rd_ent_s1.len} == nbits_q)
		             && ({2'b00, rd_ent_s1.code} == accum_q);
		miss_done  = rd_vld_s1 && rd_last_s1 && !hit;
		// a new result lands in the output register this cycle
		res_load   = (q_pop && (q_cmd.op == OP_BIT) && (next_nbits >= MAX_BITS))
		             || ((st_q == ST_SCAN) && hit);
		wr_ent.sym  = q_cmd.symbol[SW-1:0];
		wr_ent.len  = q_cmd.length;
		wr_ent.code = q_cmd.code;
	end

	always_ff @(posedge clk) begin
		if (q_pop && (q_cmd.op == OP_LOAD) && room) begin
			mem[count_q[AW-1:0]] <= wr_ent;
		end
	end

	always_ff @(posedge clk) begin
		rd_ent_s1 <= mem[scan_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			count_q    <= '0;
			scan_q     <= '0;
			accum_q    <= '0;
			nbits_q    <= '0;
			rd_vld_s1  <= 1'b0;
			rd_last_s1 <= 1'b0;
			m_valid_q  <= 1'b0;
			m_symbol_q <= '0;
			m_status_q <= 1'b0;
		end else begin
			if (m_valid_q && m_ready && !res_load) begin
				m_valid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					rd_vld_s1 <= 1'b0;
					if (q_pop) begin
						case (q_cmd.op)
							OP_CLEAR: begin
								count_q <= '0;
								accum_q <= '0;
								nbits_q <= '0;
							end
							OP_LOAD: begin
								if (room) begin
									count_q <= count_q + 1'b1;
								end
							end
							OP_BIT: begin
								if (next_nbits >= MAX_BITS) begin
									// no entry is that long: report unknown code
									m_valid_q  <= 1'b1;
									m_symbol_q <= '0;
									m_status_q <= 1'b1;
									accum_q    <= '0;
									nbits_q    <= '0;
								end else begin
									accum_q <= next_accum;
									nbits_q <= next_nbits;
									if (count_q != '0) begin
										st_q   <= ST_SCAN;
										scan_q <= '0;
									end
								end
							end
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					// one table read per cycle, compared once the read entry is registered
					rd_vld_s1  <= issue && !hit;
					rd_last_s1 <= (CW'(scan_q + 1'b1) == count_q);
					if (issue) begin
						scan_q <= scan_q + 1'b1;
					end
					if (hit) begin
						m_valid_q  <= 1'b1;
						m_symbol_q <= SYM_W'(rd_ent_s1.sym);
						m_status_q <= 1'b0;
						accum_q    <= '0;
						nbits_q    <= '0;
						st_q       <= ST_IDLE;
					end else if (miss_done) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign m_valid         = m_valid_q;
	assign m_symbol        = m_symbol_q;
	assign m_status        = m_status_q;
	assign stat.scanning   = (st_q == ST_SCAN);
	assign stat.bits_taken = nbits_q;

endmodule

// ----- rtl/core/huffman_table_bit_decoder_unit.sv -----
// Bit-serial Huffman decoder over a loaded code table. Clear items empty the table,
// load items append entries, bit items feed the code accumulator MSB first. A front
// end and a four-deep command queue take one item per cycle while the queue has room
// and the back end works. A bit item that is the 17th bit gives an error result, and
// one on an empty table needs no scan; otherwise the back end scans the table memory
// through its single read port, one entry per cycle, until an entry matches or every
// loaded entry is compared, and it takes no new item while it scans.
// The decoded symbol waits in an output register; the next bit item is held back
// until that register is free. No clearing pass is needed after reset.
module huffman_table_bit_decoder_unit #(
	parameter int TABLE_DEPTH = 256,
	parameter int SYMBOL_BITS = 10
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// entry_symbol[9:0], entry_length[13:10], entry_code[28:14], code_bit[29], zeros
	input  logic [htbd_pkg::S_TDATA_W-1:0] s_tdata,
	// func[1:0]
	input  logic [htbd_pkg::FUNC_W-1:0]    s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// symbol[9:0], zeros
	output logic [htbd_pkg::M_TDATA_W-1:0] m_tdata,
	// status[0]
	output logic                           m_tuser
);
	import htbd_pkg::*;

	logic             fq_valid;
	logic             fq_ready;
	cmd_t             fq_cmd;
	logic             qb_valid;
	logic             qb_pop;
	cmd_t             qb_cmd;
	logic [SYM_W-1:0] symbol;
	back_stat_t       stat;

	htbd_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_ready  (fq_ready),
		.q_valid  (fq_valid),
		.q_cmd    (fq_cmd)
	);

	htbd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_ready  (fq_ready),
		.in_cmd    (fq_cmd),
		.out_valid (qb_valid),
		.out_ready (qb_pop),
		.out_cmd   (qb_cmd)
	);

	htbd_back #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.SYMBOL_BITS (SYMBOL_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (qb_valid),
		.q_pop    (qb_pop),
		.q_cmd    (qb_cmd),
		.m_valid  (m_tvalid),
		.m_ready  (m_tready),
		.m_symbol (symbol),
		.m_status (m_tuser),
		.stat     (stat)
	);

	assign m_tdata = M_TDATA_W'(symbol);

	// a bit item only leaves the queue when the result register can take its result
	a_bit_pop_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		(qb_pop && (qb_cmd.op == OP_BIT)) |-> (!m_tvalid || m_tready))
		else $error("bit item popped while result register busy");

	a_err_zero_symbol: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata == '0))
		else $error("error result carries a nonzero symbol");

	a_bits_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(stat.bits_taken <= LAST_LENGTH) && (!stat.scanning || (stat.bits_taken != '0)))
		else $error("code accumulator bit count out of range");

endmodule

// ----- dv/huffman_table_bit_decoder_unit_tb.sv -----
// Self-checking testbench for the bit-serial Huffman table decoder.
// Drives directed and random stream items and checks each decoded item against its own decoder copy or a given result.
// Depends on htbd_pkg and huffman_table_bit_decoder_unit.
module huffman_table_bit_decoder_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import htbd_pkg::*;

	localparam int TABLE_DEPTH = 256;
	localparam int SYMBOL_BITS = 10;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_ITEMS = 800;
	localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              code_bit;
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  length;
		logic [SYM_W-1:0]  symbol;
	} item_t;

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic             status;
	} decoded_t;

	typedef struct packed {
		item_t    it;
		logic [4:0] reps;
		logic     typed;
		decoded_t res;
	} dir_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic [FUNC_W-1:0]    s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 m_tuser;

	// decoder copy: table, fill level, shift register and bit count
	logic [SYM_W-1:0]  tbl_symbol[TABLE_DEPTH];
	logic [LEN_W-1:0]  tbl_length[TABLE_DEPTH];
	logic [CODE_W-1:0] tbl_code[TABLE_DEPTH];
	int                loaded_count;
	logic [ACC_W-1:0]  code_shift;
	int                shift_count;

	decoded_t decoded_q[$];
	int       mismatches;
	int       useful_items;
	int       cycle_count;
	bit       quiet;

	// leaves of a random prefix code
	int                leaf_len[64];
	logic [CODE_W-1:0] leaf_code[64];
	int                n_leaves;

	huffman_table_bit_decoder_unit #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.SYMBOL_BITS(SYMBOL_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	always @(negedge clk) begin
		m_tready <= quiet || ($urandom_range(99) >= 17);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (decoded_q.size() == 0) begin
				$display("%0t: unexpected item symbol=%0d status=%0d", $time,
					m_tdata, m_tuser);
				mismatches++;
			end else begin
				decoded_t want;
				want = decoded_q.pop_front();
				if (m_tdata !== {{(M_TDATA_W-SYM_W){1'b0}}, want.symbol} ||
						m_tuser !== want.status) begin
					$display("%0t: mismatch expected symbol=%0d status=%0d, actual symbol=%0d status=%0d",
						$time, want.symbol, want.status, m_tdata, m_tuser);
					mismatches++;
				end
			end
		end
	end

	task automatic decode_step(input item_t it, output bit emitted, output decoded_t res);
		bit found;
		found = 1'b0;
		emitted = 1'b0;
		res = '0;
		case (it.func)
			FUNC_CLEAR: begin
				loaded_count = 0;
				code_shift = '0;
				shift_count = 0;
			end
			FUNC_LOAD: begin
				if (loaded_count < TABLE_DEPTH) begin
					tbl_symbol[loaded_count] = it.symbol;
					tbl_length[loaded_count] = it.length;
					tbl_code[loaded_count] = it.code;
					loaded_count++;
				end
			end
			FUNC_BIT: begin
				code_shift = {code_shift[ACC_W-2:0], it.code_bit};
				shift_count++;
				if (shift_count <= LAST_LENGTH) begin
					// earliest entry with this length and code wins
					for (int i = 0; i < loaded_count && !found; i++) begin
						if (tbl_length[i] == shift_count &&
								{{(ACC_W-CODE_W){1'b0}}, tbl_code[i]} == code_shift) begin
							found = 1'b1;
							res.symbol = tbl_symbol[i];
						end
					end
				end
				if (found || shift_count >= MAX_BITS) begin
					emitted = 1'b1;
					res.status = !found;
					code_shift = '0;
					shift_count = 0;
				end
			end
			default: ;
		endcase
	endtask

	task automatic push_item(input item_t it, input bit typed, input decoded_t typed_res);
		bit       emitted;
		decoded_t res;
		@(negedge clk);
		if (!quiet && $urandom_range(99) < 17) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 2)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {2'b00, it.code_bit, it.code, it.length, it.symbol};
		s_tuser <= it.func;
		do @(posedge clk); while (!s_tready);
		if (it.func != FUNC_NONE && !(it.func == FUNC_LOAD && loaded_count >= TABLE_DEPTH))
			useful_items++;
		decode_step(it, emitted, res);
		if (typed)
			decoded_q.push_back(typed_res);
		else if (emitted)
			decoded_q.push_back(res);
	endtask

	function automatic item_t random_item(logic [FUNC_W-1:0] f);
		item_t it;
		it.func = f;
		it.code_bit = 1'($urandom_range(1));
		it.code = CODE_W'($urandom_range(32767));
		it.length = LEN_W'($urandom_range(15));
		it.symbol = SYM_W'($urandom_range(1023));
		return it;
	endfunction

	function automatic dir_row_t stim_row(logic [FUNC_W-1:0] f, int sym, int len, int code,
			bit b, int reps, bit typed, int res_sym, bit res_status);
		dir_row_t r;
		r.it = '{func: f, code_bit: b, code: CODE_W'(code), length: LEN_W'(len),
			symbol: SYM_W'(sym)};
		r.reps = 5'(reps);
		r.typed = typed;
		r.res = '{symbol: SYM_W'(res_sym), status: res_status};
		return r;
	endfunction

	initial begin
		dir_row_t directed_rows[$];
		item_t    it;
		int       phase;
		int       target;
		int       idx;
		int       newest;
		int       pick;
		int       roll;
		int       words;

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = FUNC_CLEAR;
		m_tready = 1'b0;
		quiet = 1'b0;
		mismatches = 0;
		useful_items = 0;
		cycle_count = 0;
		loaded_count = 0;
		code_shift = '0;
		shift_count = 0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		directed_rows = '{
			// bit on an empty table, then clear restarts the shift register
			stim_row(FUNC_BIT,      0,  0,      0, 1'b1,  1, 1'b0,    0, 1'b0),
			stim_row(FUNC_CLEAR,    0,  0,      0, 1'b0,  1, 1'b0,    0, 1'b0),
			stim_row(FUNC_LOAD,  1023,  1,      1, 1'b0,  1, 1'b0,    0, 1'b0),
			// same length and code loaded later: never wins
			stim_row(FUNC_LOAD,     9,  1,      1, 1'b0,  1, 1'b0,    0, 1'b0),
			stim_row(FUNC_LOAD,     0, 15, 'h3FFF, 1'b0,  1, 1'b0,    0, 1'b0),
			// zero length never matches
			stim_row(FUNC_LOAD,    77,  0,      0, 1'b0,  1, 1'b0,    0, 1'b0),
			// code wider than its length never matches
			stim_row(FUNC_LOAD,   300,  2, 'h4002, 1'b0,  1, 1'b0,    0, 1'b0),
			// unknown func is dropped
			stim_row(FUNC_NONE,  1023, 15, 'h7FFF, 1'b1,  1, 1'b0,    0, 1'b0),
			stim_row(FUNC_BIT,      0,  0,      0, 1'b1,  1, 1'b1, 1023, 1'b0),
			stim_row(FUNC_BIT,      0,  0,      0, 1'b0,  1, 1'b0,    0, 1'b0),
			stim_row(FUNC_BIT,      0,  0,      0, 1'b1, 14, 1'b1,    0, 1'b0),
			// seventeen bits with no match end in error
			stim_row(FUNC_BIT,      0,  0,      0, 1'b0, 17, 1'b1,    0, 1'b1)
		};
		foreach (directed_rows[r]) begin
			for (int k = 0; k < directed_rows[r].reps; k++)
				push_item(directed_rows[r].it,
					directed_rows[r].typed && k == directed_rows[r].reps - 1,
					directed_rows[r].res);
		end

		useful_items = 0;
		phase = 0;
		while (useful_items < RANDOM_ITEMS) begin
			phase++;
			quiet = (phase >= 5 && phase <= 9);
			if (phase == 3) begin
				// fill the table past its depth, then decode random bits
				push_item(random_item(FUNC_CLEAR), 1'b0, '0);
				for (int k = 0; k < TABLE_DEPTH + 4; k++) begin
					it = random_item(FUNC_LOAD);
					it.length = LEN_W'($urandom_range(1, 15));
					it.code = it.code & ((15'd1 << it.length) - 15'd1);
					push_item(it, 1'b0, '0);
				end
				for (int k = 0; k < 40; k++)
					push_item(random_item(FUNC_BIT), 1'b0, '0);
				continue;
			end

			if ($urandom_range(99) < 85)
				push_item(random_item(FUNC_CLEAR), 1'b0, '0);

			// complete prefix code by splitting leaves, often the newest one
			target = ($urandom_range(9) == 0) ? $urandom_range(17, 60) : $urandom_range(2, 12);
			n_leaves = 1;
			leaf_len[0] = 0;
			leaf_code[0] = '0;
			newest = 0;
			while (n_leaves < target) begin
				idx = ($urandom_range(1) == 0) ? newest : $urandom_range(n_leaves - 1);
				if (leaf_len[idx] < 15) begin
					leaf_len[idx]++;
					leaf_code[idx] = leaf_code[idx] << 1;
					leaf_len[n_leaves] = leaf_len[idx];
					leaf_code[n_leaves] = leaf_code[idx] | 15'd1;
					newest = n_leaves;
					n_leaves++;
				end
			end

			for (int k = 0; k < n_leaves; k++) begin
				it = random_item(FUNC_LOAD);
				it.length = LEN_W'(leaf_len[k]);
				it.code = leaf_code[k];
				roll = $urandom_range(99);
				if (roll < 4)
					continue;
				else if (roll < 7)
					it.length = 0;
				else if (roll < 10 && leaf_len[k] < 15)
					it.code[$urandom_range(14, leaf_len[k])] = 1'b1;
				push_item(it, 1'b0, '0);
				if (roll >= 10 && roll < 13) begin
					it.symbol = SYM_W'($urandom_range(1023));
					push_item(it, 1'b0, '0);
				end
			end

			words = $urandom_range(10, 40);
			for (int w = 0; w < words; w++) begin
				roll = $urandom_range(99);
				if (roll < 5)
					push_item(random_item(FUNC_NONE), 1'b0, '0);
				else if (roll < 9)
					push_item(random_item(FUNC_BIT), 1'b0, '0);
				else if (roll < 10)
					push_item(random_item(FUNC_CLEAR), 1'b0, '0);
				else if (roll < 12)
					push_item(random_item(FUNC_LOAD), 1'b0, '0);
				else begin
					pick = $urandom_range(n_leaves - 1);
					for (int b = leaf_len[pick] - 1; b >= 0; b--) begin
						it = random_item(FUNC_BIT);
						it.code_bit = leaf_code[pick][b];
						push_item(it, 1'b0, '0);
					end
				end
			end
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		quiet = 1'b0;
		while (decoded_q.size() != 0) @(posedge clk);
		repeat (TABLE_DEPTH + 50) @(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ----- huffman_table_bit_decoder_unit.f -----
rtl/core/htbd_pkg.sv
rtl/core/htbd_front.sv
rtl/core/htbd_queue.sv
rtl/core/htbd_back.sv
rtl/core/huffman_table_bit_decoder_unit.sv
dv/huffman_table_bit_decoder_unit_tb.sv
